// ===== rtl/isl_pkg.sv =====
package isl_pkg;

    // Command codes
    typedef enum logic [3:0] {
        CMD_ADD_FIRST    = 4'd0,
        CMD_ADD_LAST     = 4'd1,
        CMD_INSERT_AT    = 4'd2,
        CMD_REMOVE_FIRST = 4'd3,
        CMD_REMOVE_LAST  = 4'd4,
        CMD_REMOVE_AT    = 4'd5,
        CMD_GET_FIRST    = 4'd6,
        CMD_GET_LAST     = 4'd7,
        CMD_GET_AT       = 4'd8,
        CMD_SET_AT       = 4'd9
    } t_cmd;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_RANGE = 2'd2,
        ST_FULL  = 2'd3
    } t_status;

    // Walker status seen by the sequencer
    typedef struct packed {
        logic busy;     // reads left or a read still in flight
        logic capture;  // this cycle's read data is the result word
    } t_walk_stat;

endpackage

// ===== rtl/isl_mem.sv =====
module isl_mem #(
    parameter int DEPTH = 64,
    parameter int DW    = 32
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [DW-1:0]            i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [DW-1:0]            o_rd_data
);
    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rd_data;

    // One write port, one registered read port (read-first)
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/isl_walk.sv =====
module isl_walk #(
    parameter int AW = 6
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [AW-1:0]       i_first,
    input  logic [AW-1:0]       i_last,
    input  logic                i_down,
    input  logic                i_cap_first,
    output logic                o_rd_en,
    output logic [AW-1:0]       o_rd_addr,
    output logic                o_wr_en,
    output logic [AW-1:0]       o_wr_addr,
    output isl_pkg::t_walk_stat o_stat
);
    import isl_pkg::*;

    logic          r_active;
    logic [AW-1:0] r_idx;
    logic [AW-1:0] r_last;
    logic          r_down;
    logic          r_cap_next;
    logic          r_pend;
    logic          r_pend_cap;
    logic [AW-1:0] r_wa;

    // Control: active walk and read in flight
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_pend   <= 1'b0;
        end else if (i_start) begin
            r_active <= 1'b1;
            r_pend   <= 1'b0;
        end else begin
            r_pend <= r_active;
            if (r_active && (r_idx == r_last)) begin
                r_active <= 1'b0;
            end
        end
    end

    // Index walk: read one entry a cycle, its data lands one slot over
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_idx      <= i_first;
            r_last     <= i_last;
            r_down     <= i_down;
            r_cap_next <= i_cap_first;
        end else if (r_active) begin
            r_wa       <= r_down ? (r_idx + 1'b1) : (r_idx - 1'b1);
            r_pend_cap <= r_cap_next;
            r_cap_next <= 1'b0;
            r_idx      <= r_down ? (r_idx - 1'b1) : (r_idx + 1'b1);
        end
    end

    assign o_rd_en        = r_active && !i_start;
    assign o_rd_addr      = r_idx;
    assign o_wr_en        = r_pend && !r_pend_cap;
    assign o_wr_addr      = r_wa;
    assign o_stat.busy    = r_active || r_pend;
    assign o_stat.capture = r_pend && r_pend_cap;

endmodule

// ===== rtl/indexed_sequence_list_unit.sv =====
// Flow: accept, then walk the elements one per cycle, then an optional final
//   store and the result register.
// One command at a time: the input stalls until the result is loaded; the
//   one-read, one-write element memory shifts one entry per cycle.
// Reset (synchronous, active low) empties the list and drops any pending result.
module indexed_sequence_list_unit #(
    parameter int CAPACITY   = 64,
    parameter int DATA_WIDTH = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [3:0]            i_command,
    input  logic [6:0]            i_position,
    input  logic [31:0]           i_data_in,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [31:0]           o_data_out,
    output isl_pkg::t_status      o_status,
    output logic [6:0]            o_count,
    output logic                  o_is_empty
);
    import isl_pkg::*;

    localparam int AW   = $clog2(CAPACITY);
    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int CMPW = (CW > 7) ? CW : 7;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_MOVE = 4'b0010,
        S_FIN  = 4'b0100,
        S_DONE = 4'b1000
    } t_state;

    t_state          r_state, n_state;
    logic [CW-1:0]   r_count, n_count;
    t_status         r_status, n_status;
    logic            r_fin, n_fin;
    logic [AW-1:0]   r_fin_addr, n_fin_addr;
    logic [DATA_WIDTH-1:0] r_v;
    logic [DATA_WIDTH-1:0] r_dout;
    logic            r_out_valid;
    logic [31:0]     r_out_data;
    t_status         r_out_status;
    logic [6:0]      r_out_count;
    logic            r_out_empty;

    logic            acc;
    logic            w_start;
    logic [AW-1:0]   w_first, w_last;
    logic            w_down, w_cap_first;
    t_walk_stat      w_stat;
    logic            w_rd_en, w_wr_en;
    logic [AW-1:0]   w_rd_addr, w_wr_addr;
    logic [DATA_WIDTH-1:0] rd_data;
    logic            mem_we;
    logic [AW-1:0]   mem_wa;
    logic [DATA_WIDTH-1:0] mem_wd;
    logic            out_load;

    logic            full, empty, elem_ok, ins_ok, at_end;
    logic [AW-1:0]   p_idx, c_idx, cm1_idx;
    t_cmd            cmd;

    assign acc        = i_in_valid && (r_state == S_IDLE);
    assign o_in_stall = (r_state != S_IDLE);

    // Bounds checks against the current count
    assign cmd     = t_cmd'(i_command);
    assign full    = (r_count == CW'(CAPACITY));
    assign empty   = (r_count == '0);
    assign elem_ok = CMPW'(i_position) <  CMPW'(r_count);
    assign ins_ok  = CMPW'(i_position) <= CMPW'(r_count);
    assign at_end  = CMPW'(i_position) == CMPW'(r_count);
    assign p_idx   = AW'(i_position);
    assign c_idx   = AW'(r_count);
    assign cm1_idx = AW'(r_count - 1'b1);

    // Command decode and sequencer
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_status    = r_status;
        n_fin       = r_fin;
        n_fin_addr  = r_fin_addr;
        w_start     = 1'b0;
        w_first     = '0;
        w_last      = '0;
        w_down      = 1'b0;
        w_cap_first = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state    = S_DONE;
                    n_status   = ST_OK;
                    n_fin      = 1'b0;
                    n_fin_addr = p_idx;
                    case (cmd)
                        CMD_ADD_FIRST: begin
                            if (full) begin
                                n_status = ST_FULL;
                            end else begin
                                n_count    = r_count + 1'b1;
                                n_fin      = 1'b1;
                                n_fin_addr = '0;
                                n_state    = empty ? S_FIN : S_MOVE;
                                w_start    = !empty;
                                w_first    = cm1_idx;
                                w_down     = 1'b1;
                            end
                        end
                        CMD_ADD_LAST: begin
                            if (full) begin
                                n_status = ST_FULL;
                            end else begin
                                n_count    = r_count + 1'b1;
                                n_fin      = 1'b1;
                                n_fin_addr = c_idx;
                                n_state    = S_FIN;
                            end
                        end
                        CMD_INSERT_AT: begin
                            if (!ins_ok) begin
                                n_status = ST_RANGE;
                            end else if (full) begin
                                n_status = ST_FULL;
                            end else begin
                                n_count = r_count + 1'b1;
                                n_fin   = 1'b1;
                                n_state = at_end ? S_FIN : S_MOVE;
                                w_start = !at_end;
                                w_first = cm1_idx;
                                w_last  = p_idx;
                                w_down  = 1'b1;
                            end
                        end
                        CMD_REMOVE_FIRST, CMD_REMOVE_LAST, CMD_REMOVE_AT: begin
                            if ((cmd == CMD_REMOVE_AT) ? !elem_ok : empty) begin
                                n_status = (cmd == CMD_REMOVE_AT) ? ST_RANGE : ST_EMPTY;
                            end else begin
                                n_count     = r_count - 1'b1;
                                n_state     = S_MOVE;
                                w_start     = 1'b1;
                                w_first     = (cmd == CMD_REMOVE_FIRST) ? '0 :
                                              (cmd == CMD_REMOVE_LAST) ? cm1_idx : p_idx;
                                w_last      = cm1_idx;
                                w_cap_first = 1'b1;
                            end
                        end
                        CMD_GET_FIRST, CMD_GET_LAST: begin
                            if (empty) begin
                                n_status = ST_EMPTY;
                            end else begin
                                n_state     = S_MOVE;
                                w_start     = 1'b1;
                                w_first     = (cmd == CMD_GET_FIRST) ? '0 : cm1_idx;
                                w_last      = w_first;
                                w_cap_first = 1'b1;
                            end
                        end
                        CMD_GET_AT, CMD_SET_AT: begin
                            if (!elem_ok) begin
                                n_status = ST_RANGE;
                            end else begin
                                n_state     = S_MOVE;
                                n_fin       = (cmd == CMD_SET_AT);
                                w_start     = 1'b1;
                                w_first     = p_idx;
                                w_last      = p_idx;
                                w_cap_first = 1'b1;
                            end
                        end
                        default: begin
                            n_status = ST_OK;
                        end
                    endcase
                end
            end
            S_MOVE: begin
                if (!w_stat.busy) begin
                    n_state = r_fin ? S_FIN : S_DONE;
                end
            end
            S_FIN: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign out_load = (r_state == S_DONE) && (!r_out_valid || !i_out_stall);

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Command payload and result word
    always_ff @(posedge i_clk) begin
        r_status   <= n_status;
        r_fin      <= n_fin;
        r_fin_addr <= n_fin_addr;
        if (acc) begin
            r_v    <= DATA_WIDTH'(i_data_in);
            r_dout <= '0;
        end else if (w_stat.capture) begin
            r_dout <= rd_data;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_data   <= 32'(r_dout);
            r_out_status <= r_status;
            r_out_count  <= 7'(r_count);
            r_out_empty  <= (r_count == '0);
        end
    end

    // Memory write select: walker shift or final store
    assign mem_we = w_wr_en || (r_state == S_FIN);
    assign mem_wa = (r_state == S_FIN) ? r_fin_addr : w_wr_addr;
    assign mem_wd = (r_state == S_FIN) ? r_v : rd_data;

    isl_walk #(
        .AW(AW)
    ) u_walk (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (acc && w_start),
        .i_first     (w_first),
        .i_last      (w_last),
        .i_down      (w_down),
        .i_cap_first (w_cap_first),
        .o_rd_en     (w_rd_en),
        .o_rd_addr   (w_rd_addr),
        .o_wr_en     (w_wr_en),
        .o_wr_addr   (w_wr_addr),
        .o_stat      (w_stat)
    );

    isl_mem #(
        .DEPTH(CAPACITY),
        .DW   (DATA_WIDTH)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (mem_we),
        .i_wr_addr (mem_wa),
        .i_wr_data (mem_wd),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (rd_data)
    );

    assign o_out_valid = r_out_valid;
    assign o_data_out  = r_out_data;
    assign o_status    = r_out_status;
    assign o_count     = r_out_count;
    assign o_is_empty  = r_out_empty;

endmodule

// ===== rtl/isl_check.sv =====
module isl_check (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_in_valid,
    input logic             o_in_stall,
    input logic             o_out_valid,
    input logic             i_out_stall,
    input logic [31:0]      o_data_out,
    input isl_pkg::t_status o_status,
    input logic [6:0]       o_count,
    input logic             o_is_empty
);
    import isl_pkg::*;

    // Reset drops any pending result
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_data_out)
            && $stable(o_status) && $stable(o_count))
        else $error("stalled result changed");

    // One command at a time: a transfer in closes the input side
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input open right after a transfer");

    // Errors return zero data; empty and full errors agree with the count
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status != ST_OK) |-> o_data_out == 32'd0)
        else $error("error result carries data");

    a_err_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_status != ST_EMPTY || o_is_empty)
            && (o_status != ST_FULL || !o_is_empty)
            && (!o_is_empty || o_count == 7'd0))
        else $error("status disagrees with element count");

endmodule

bind indexed_sequence_list_unit isl_check u_isl_check (.*);

// ===== dv/indexed_sequence_list_unit_test.sv =====
module indexed_sequence_list_unit_test;
    import isl_pkg::*;

    localparam int LIST_DEPTH  = 64;
    localparam int WALK_CYCLES = LIST_DEPTH + 8;
    localparam int HOLD_CYCLES = 400;
    localparam int RANDOM_CMDS = 2000;
    localparam int CYCLE_LIMIT = 1000000;

    // Codes outside the command set; the block must ignore them
    localparam logic [3:0] CMD_UNUSED_LO = 4'd10;
    localparam logic [3:0] CMD_UNUSED_HI = 4'd15;

    typedef struct {
        logic [3:0]  cmd;
        logic [6:0]  pos;
        logic [31:0] data;
    } t_list_cmd;

    typedef struct {
        logic [31:0] data_out;
        t_status     status;
        logic [6:0]  count;
        logic        is_empty;
    } t_list_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [3:0]  i_command = '0;
    logic [6:0]  i_position = '0;
    logic [31:0] i_data_in = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [31:0] o_data_out;
    t_status     o_status;
    logic [6:0]  o_count;
    logic        o_is_empty;

    t_list_cmd    pending_cmds[$];
    t_list_result expected_results[$];
    logic [31:0]  list_words[$];

    t_list_cmd    next_cmd;
    t_list_result got_exp;
    logic      in_taken = 1'b0;
    int        items_taken = 0;
    int        known_sent = 0;
    int        fail_count = 0;
    int        cycle_cnt = 0;
    int        hold_left = 0;
    int        hold_mark = 300;
    wire       calm_window = (items_taken >= 600) && (items_taken < 900);

    indexed_sequence_list_unit #(
        .CAPACITY  (LIST_DEPTH),
        .DATA_WIDTH(32)
    ) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_command  (i_command),
        .i_position (i_position),
        .i_data_in  (i_data_in),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_data_out (o_data_out),
        .o_status   (o_status),
        .o_count    (o_count),
        .o_is_empty (o_is_empty)
    );

    always #5 i_clk = ~i_clk;

    // Apply one command to the shadow list and return the result it should give
    function automatic t_list_result apply_list_cmd(input logic [3:0] cmd,
                                                    input logic [6:0] pos,
                                                    input logic [31:0] din);
        t_list_result r;
        int n;
        int p;
        n = list_words.size();
        p = int'(pos);
        r.data_out = '0;
        r.status   = ST_OK;
        case (cmd)
            CMD_ADD_FIRST: begin
                if (n >= LIST_DEPTH) r.status = ST_FULL;
                else list_words.push_front(din);
            end
            CMD_ADD_LAST: begin
                if (n >= LIST_DEPTH) r.status = ST_FULL;
                else list_words.insert(n, din);
            end
            CMD_INSERT_AT: begin
                // range is checked ahead of full
                if (p > n) r.status = ST_RANGE;
                else if (n >= LIST_DEPTH) r.status = ST_FULL;
                else list_words.insert(p, din);
            end
            CMD_REMOVE_FIRST: begin
                if (n == 0) r.status = ST_EMPTY;
                else r.data_out = list_words.pop_front();
            end
            CMD_REMOVE_LAST: begin
                if (n == 0) r.status = ST_EMPTY;
                else r.data_out = list_words.pop_back();
            end
            CMD_REMOVE_AT: begin
                if (p >= n) begin
                    r.status = ST_RANGE;
                end else begin
                    r.data_out = list_words[p];
                    list_words.delete(p);
                end
            end
            CMD_GET_FIRST: begin
                if (n == 0) r.status = ST_EMPTY;
                else r.data_out = list_words[0];
            end
            CMD_GET_LAST: begin
                if (n == 0) r.status = ST_EMPTY;
                else r.data_out = list_words[n - 1];
            end
            CMD_GET_AT: begin
                if (p >= n) r.status = ST_RANGE;
                else r.data_out = list_words[p];
            end
            CMD_SET_AT: begin
                if (p >= n) begin
                    r.status = ST_RANGE;
                end else begin
                    r.data_out = list_words[p];
                    list_words[p] = din;
                end
            end
            default: ;
        endcase
        r.count    = 7'(list_words.size());
        r.is_empty = (list_words.size() == 0);
        return r;
    endfunction

    // Queue one command for the driver, keeping only a short backlog
    task automatic send_cmd(input logic [3:0] cmd, input logic [6:0] pos,
                            input logic [31:0] data);
        t_list_cmd c;
        while (pending_cmds.size() >= 2) @(posedge i_clk);
        c.cmd  = cmd;
        c.pos  = pos;
        c.data = data;
        pending_cmds.insert(pending_cmds.size(), c);
        if (cmd <= CMD_SET_AT) known_sent++;
    endtask

    // Input driver: new transfer only once the previous one is taken
    always @(negedge i_clk) begin
        if (i_rst_n && (!i_in_valid || in_taken)) begin
            if (pending_cmds.size() > 0 && (calm_window || $urandom_range(0, 99) >= 34)) begin
                next_cmd = pending_cmds.pop_front();
                i_in_valid <= 1'b1;
                i_command  <= next_cmd.cmd;
                i_position <= next_cmd.pos;
                i_data_in  <= next_cmd.data;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Output stall: random, quiet window, and long hold-offs to back up the block
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else if (hold_left > 0) begin
            i_out_stall <= 1'b1;
            hold_left   <= hold_left - 1;
        end else if (items_taken >= hold_mark) begin
            i_out_stall <= 1'b1;
            hold_left   <= HOLD_CYCLES;
            hold_mark   <= hold_mark + 900;
        end else begin
            i_out_stall <= calm_window ? 1'b0 : ($urandom_range(0, 99) < 34);
        end
    end

    // Monitor: predict on input transfer, check on output transfer
    always @(posedge i_clk) begin
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("%0t timeout after %0d cycles", $time, cycle_cnt);
            $display("RESULT: ERROR");
            $finish;
        end else if (i_rst_n) begin
            cycle_cnt++;
            in_taken = i_in_valid && !o_in_stall;
            if (in_taken) begin
                expected_results.insert(expected_results.size(),
                                        apply_list_cmd(i_command, i_position, i_data_in));
                items_taken++;
            end
            if (o_out_valid && !i_out_stall) begin
                if (expected_results.size() == 0) begin
                    $display("%0t unexpected result: data %h status %0d count %0d",
                             $time, o_data_out, o_status, o_count);
                    fail_count++;
                end else begin
                    got_exp = expected_results.pop_front();
                    if (o_data_out !== got_exp.data_out) begin
                        $display("%0t data_out: expected %h actual %h",
                                 $time, got_exp.data_out, o_data_out);
                        fail_count++;
                    end
                    if (o_status !== got_exp.status) begin
                        $display("%0t status: expected %0d actual %0d",
                                 $time, got_exp.status, o_status);
                        fail_count++;
                    end
                    if (o_count !== got_exp.count) begin
                        $display("%0t count: expected %0d actual %0d",
                                 $time, got_exp.count, o_count);
                        fail_count++;
                    end
                    if (o_is_empty !== got_exp.is_empty) begin
                        $display("%0t is_empty: expected %b actual %b",
                                 $time, got_exp.is_empty, o_is_empty);
                        fail_count++;
                    end
                end
            end
        end
    end

    // Reset, stimulus and end of test
    initial begin
        int hint;
        int guard;
        logic [3:0] c;
        logic [6:0] p;

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Empty list corner cases
        send_cmd(CMD_REMOVE_FIRST, 7'd0, 32'h0);
        send_cmd(CMD_REMOVE_LAST, 7'd0, 32'h0);
        send_cmd(CMD_GET_FIRST, 7'd0, 32'h0);
        send_cmd(CMD_GET_LAST, 7'd0, 32'h0);
        send_cmd(CMD_REMOVE_AT, 7'd0, 32'h0);
        send_cmd(CMD_GET_AT, 7'd0, 32'h0);
        send_cmd(CMD_SET_AT, 7'd0, 32'hFFFF_FFFF);
        send_cmd(CMD_INSERT_AT, 7'd1, 32'hFFFF_FFFF);
        send_cmd(CMD_UNUSED_HI, 7'd127, 32'hFFFF_FFFF);
        // Build a short list, then read, overwrite and remove entries from it
        send_cmd(CMD_ADD_FIRST, 7'd0, 32'hFFFF_FFFF);
        send_cmd(CMD_ADD_LAST, 7'd0, 32'h0);
        send_cmd(CMD_INSERT_AT, 7'd2, 32'hA5A5_A5A5);
        send_cmd(CMD_INSERT_AT, 7'd0, 32'h5A5A_5A5A);
        send_cmd(CMD_INSERT_AT, 7'd127, 32'h1);
        send_cmd(CMD_GET_FIRST, 7'd0, 32'h0);
        send_cmd(CMD_GET_LAST, 7'd0, 32'h0);
        send_cmd(CMD_GET_AT, 7'd3, 32'h0);
        send_cmd(CMD_GET_AT, 7'd64, 32'h0);
        send_cmd(CMD_SET_AT, 7'd1, 32'h1234_5678);
        send_cmd(CMD_REMOVE_AT, 7'd1, 32'h0);
        send_cmd(CMD_REMOVE_AT, 7'd127, 32'h0);
        send_cmd(CMD_REMOVE_FIRST, 7'd0, 32'h0);
        send_cmd(CMD_REMOVE_LAST, 7'd0, 32'h0);
        send_cmd(CMD_UNUSED_LO, 7'd0, 32'h0);

        // Random episodes: fill to full, drain to empty, or mixed traffic
        while (known_sent < RANDOM_CMDS + 25) begin
            case ($urandom_range(0, 3))
                0: begin
                    guard = 0;
                    while (list_words.size() < LIST_DEPTH && guard < 200) begin
                        hint = list_words.size();
                        c = 4'($urandom_range(CMD_ADD_FIRST, CMD_INSERT_AT));
                        send_cmd(c, 7'($urandom_range(0, hint)), $urandom());
                        guard++;
                    end
                    // adds against a full list, some with a bad index
                    repeat ($urandom_range(1, 4)) begin
                        hint = list_words.size();
                        c = 4'($urandom_range(CMD_ADD_FIRST, CMD_INSERT_AT));
                        send_cmd(c, 7'($urandom_range(hint, hint + 2)), $urandom());
                    end
                end
                1: begin
                    guard = 0;
                    while (list_words.size() > 0 && guard < 200) begin
                        hint = list_words.size();
                        c = 4'($urandom_range(CMD_REMOVE_FIRST, CMD_REMOVE_AT));
                        p = (hint > 0) ? 7'($urandom_range(0, hint - 1)) : 7'd0;
                        send_cmd(c, p, $urandom());
                        guard++;
                    end
                    // removes, reads and sets on an empty list
                    repeat ($urandom_range(1, 4)) begin
                        c = 4'($urandom_range(CMD_REMOVE_FIRST, CMD_SET_AT));
                        send_cmd(c, 7'($urandom_range(0, 2)), $urandom());
                    end
                end
                default: begin
                    repeat ($urandom_range(20, 60)) begin
                        hint = list_words.size();
                        if ($urandom_range(0, 99) < 8)
                            c = 4'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI));
                        else
                            c = 4'($urandom_range(CMD_ADD_FIRST, CMD_SET_AT));
                        if ($urandom_range(0, 99) < 12) p = 7'($urandom_range(0, 127));
                        else p = 7'($urandom_range(0, hint));
                        send_cmd(c, p, $urandom());
                    end
                end
            endcase
        end

        // Drain: every transfer taken and every result seen
        while (pending_cmds.size() != 0 || i_in_valid || expected_results.size() != 0)
            @(posedge i_clk);
        repeat (WALK_CYCLES) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/isl_pkg.sv
rtl/isl_mem.sv
rtl/isl_walk.sv
rtl/indexed_sequence_list_unit.sv
rtl/isl_check.sv
dv/indexed_sequence_list_unit_test.sv
